>>> rtl/load_store_address_and_transfer_defines.svh
// ----------------------------------------------------------------------------
// load_store_address_and_transfer_defines
// Assertion macros shared by the load/store block.
// ----------------------------------------------------------------------------
`ifndef LOAD_STORE_ADDRESS_AND_TRANSFER_DEFINES_SVH
`define LOAD_STORE_ADDRESS_AND_TRANSFER_DEFINES_SVH

// checked only while out of reset
`define LSAT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LSAT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/lsat_pkg.sv
// ----------------------------------------------------------------------------
// lsat_pkg
// Types and constants of the load/store address and transfer block.
// ----------------------------------------------------------------------------
package lsat_pkg;

    localparam int DATA_W        = 64;
    localparam int WORD_W        = 32;
    localparam int REG_N         = 32;
    localparam int REG_AW        = 5;
    localparam int OFF_W         = 12;
    localparam int SIMM_W        = 9;
    localparam int WIDX_W        = 14;
    localparam int CMD_W         = 2;
    localparam int MEM_WORDS_DEF = 16384;
    // byte address bits above the word offset
    localparam int WADDR_W       = DATA_W - 2;
    // address bits per residue chunk of the word index fold
    localparam int RED_CH        = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_EXEC  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_RED,
        S_MEM0,
        S_MEM1,
        S_FIN
    } t_state;

    typedef struct packed {
        logic take_in;
        logic calc_addr;
        logic red_step;
        logic mem_first;
        logic mem_second;
        logic finish;
    } t_dp_ctl;

    typedef struct packed {
        logic wide;
        logic red_last;
    } t_dp_sts;

endpackage

>>> rtl/lsat_dpath.sv
// ----------------------------------------------------------------------------
// lsat_dpath
// Register file, address adder, word index reduction and data memory.
// ----------------------------------------------------------------------------
module lsat_dpath
    import lsat_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_ctl           i_ctl,
    output t_dp_sts           o_sts,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [OFF_W-1:0]  i_offset_field,
    input  logic [REG_AW-1:0] i_base_reg,
    input  logic [REG_AW-1:0] i_target_reg,
    input  logic              i_wide,
    input  logic              i_is_load,
    input  logic              i_unsigned_mode,
    input  logic [DATA_W-1:0] i_reg_data,
    output logic [DATA_W-1:0] o_result_data,
    output logic [WIDX_W-1:0] o_word_index
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam bit POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam logic [AW:0] MW = (AW+1)'(MEM_WORDS);
    localparam int RED_N = (WADDR_W + RED_CH - 1) / RED_CH;
    localparam int SH_W  = RED_N * RED_CH;
    localparam int SUM_W = AW + $clog2(RED_CH);

    logic [CMD_W-1:0]  r_cmd;
    logic [OFF_W-1:0]  r_off;
    logic [REG_AW-1:0] r_base;
    logic [REG_AW-1:0] r_rt;
    logic              r_wide;
    logic              r_load;
    logic              r_umode;
    logic [DATA_W-1:0] r_regdata;

    logic [DATA_W-1:0] r_rf [REG_N];
    logic [REG_N-1:0]  r_vld;
    logic [DATA_W-1:0] r_rda;
    logic [DATA_W-1:0] r_rdb;

    logic [WADDR_W-1:0]          r_sh;
    logic                        r_cnt;
    logic [RED_N-1:0][AW-1:0]    r_part;
    logic [AW-1:0]               r_w0;

    logic [WORD_W-1:0] r_mem [MEM_WORDS];
    logic [WORD_W-1:0] r_mrd;
    logic [WORD_W-1:0] r_hi;

    logic [DATA_W-1:0] r_result;
    logic [WIDX_W-1:0] r_widx;

    logic [REG_AW-1:0] ra_a;
    logic [REG_AW-1:0] ra_b;
    logic              rf_we;
    logic [REG_AW-1:0] rf_wa;
    logic [DATA_W-1:0] rf_wd;

    logic              is_idx;
    logic [DATA_W-1:0] addend;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] addr;
    logic [SH_W-1:0]   sh_pad;
    logic [RED_N-1:0][AW-1:0] part_bus;
    logic [SUM_W-1:0]  part_sum;
    logic [AW:0]       w0_inc;
    logic [AW-1:0]     w1;
    logic [AW-1:0]     m_addr;
    logic              m_we;
    logic [WORD_W-1:0] m_wd;
    logic [DATA_W-1:0] fin_data;
    logic [AW+WIDX_W-1:0] widx_ext;

    // 2^j mod MEM_WORDS
    function automatic logic [AW-1:0] pw_mod(int j);
        logic [AW:0] v;
        v = (AW+1)'(1);
        for (int k = 0; k < j; k++) begin
            v = v << 1;
            if (v >= MW) begin
                v = v - MW;
            end
        end
        return v[AW-1:0];
    endfunction

    // s mod MEM_WORDS for s below RED_CH * MEM_WORDS
    function automatic logic [AW-1:0] red_mod(logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = s;
        for (int k = 1; k < RED_CH; k++) begin
            if (s >= SUM_W'(k * MEM_WORDS)) begin
                r = s - SUM_W'(k * MEM_WORDS);
            end
        end
        return r[AW-1:0];
    endfunction

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_in) begin
            r_cmd     <= i_command;
            r_off     <= i_offset_field;
            r_base    <= i_base_reg;
            r_rt      <= i_target_reg;
            r_wide    <= i_wide;
            r_load    <= i_is_load;
            r_umode   <= i_unsigned_mode;
            r_regdata <= i_reg_data;
        end
    end

    // register file: two registered read ports, one write port
    assign ra_a = (i_command == CMD_READ) ? i_target_reg : i_base_reg;
    assign ra_b = i_ctl.take_in ? i_offset_field[10:6] : r_rt;

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        if (i_ctl.take_in) begin
            r_rda <= r_vld[ra_a] ? r_rf[ra_a] : '0;
        end
        if (i_ctl.take_in || i_ctl.red_step) begin
            r_rdb <= r_vld[ra_b] ? r_rf[ra_b] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (rf_we) begin
            r_vld[rf_wa] <= 1'b1;
        end
    end

    // address generation
    assign is_idx = !r_umode && !r_off[11];

    always_comb begin
        if (r_umode) begin
            addend = {{(DATA_W-OFF_W){1'b0}}, r_off};
        end else if (!r_off[11]) begin
            addend = {{(DATA_W-SIMM_W){r_off[10]}}, r_off[10:2]};
        end else begin
            addend = r_rdb;
        end
        sum  = r_rda + addend;
        addr = (is_idx && !r_off[1]) ? r_rda : sum;
    end

    // word index = (addr / 4) mod MEM_WORDS: per-chunk residue sums, then one fold
    assign sh_pad = SH_W'(r_sh);

    for (genvar c = 0; c < RED_N; c++) begin : g_chunk
        logic [RED_CH-1:0][SUM_W-1:0] term;
        logic [SUM_W-1:0]             acc;
        for (genvar b = 0; b < RED_CH; b++) begin : g_bit
            localparam logic [SUM_W-1:0] PW = SUM_W'(pw_mod(RED_CH * c + b));
            assign term[b] = sh_pad[RED_CH * c + b] ? PW : '0;
        end
        always_comb begin
            acc = '0;
            for (int b = 0; b < RED_CH; b++) begin
                acc = acc + term[b];
            end
        end
        assign part_bus[c] = red_mod(acc);
    end

    always_comb begin
        part_sum = '0;
        for (int k = 0; k < RED_N; k++) begin
            part_sum = part_sum + SUM_W'(r_part[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc_addr) begin
            r_sh  <= addr[DATA_W-1:2];
            r_cnt <= 1'b0;
        end else if (i_ctl.red_step) begin
            r_cnt <= 1'b1;
            if (!r_cnt) begin
                r_part <= part_bus;
            end
            if (POW2) begin
                r_w0 <= r_sh[AW-1:0];
            end else if (r_cnt) begin
                r_w0 <= red_mod(part_sum);
            end
        end
    end

    assign w0_inc = {1'b0, r_w0} + (AW+1)'(1);
    assign w1     = (w0_inc == MW) ? '0 : w0_inc[AW-1:0];

    // data memory
    assign m_addr = i_ctl.mem_second ? w1 : r_w0;
    assign m_we   = !r_load && (i_ctl.mem_first || i_ctl.mem_second);
    assign m_wd   = (i_ctl.mem_first && r_wide) ? r_rdb[DATA_W-1:WORD_W] : r_rdb[WORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            r_mem[m_addr] <= m_wd;
        end
        if (r_load && (i_ctl.mem_first || i_ctl.mem_second)) begin
            r_mrd <= r_mem[m_addr];
        end
        if (i_ctl.mem_second) begin
            r_hi <= r_mrd;
        end
    end

    // result composition
    always_comb begin
        case (r_cmd)
            CMD_WRITE: fin_data = r_regdata;
            CMD_READ:  fin_data = r_rda;
            CMD_EXEC: begin
                if (r_load) begin
                    fin_data = r_wide ? {r_hi, r_mrd} : {{WORD_W{1'b0}}, r_mrd};
                end else begin
                    fin_data = r_wide ? r_rdb : {{WORD_W{1'b0}}, r_rdb[WORD_W-1:0]};
                end
            end
            default:   fin_data = '0;
        endcase
    end

    always_comb begin
        rf_we = 1'b0;
        rf_wa = r_rt;
        rf_wd = fin_data;
        if (i_ctl.calc_addr && is_idx) begin
            rf_we = 1'b1;
            rf_wa = r_base;
            rf_wd = sum;
        end else if (i_ctl.finish &&
                     ((r_cmd == CMD_WRITE) || ((r_cmd == CMD_EXEC) && r_load))) begin
            rf_we = 1'b1;
        end
    end

    assign widx_ext = {{WIDX_W{1'b0}}, r_w0};

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_result <= fin_data;
            r_widx   <= (r_cmd == CMD_EXEC) ? widx_ext[WIDX_W-1:0] : '0;
        end
    end

    assign o_result_data  = r_result;
    assign o_word_index   = r_widx;
    assign o_sts.wide     = r_wide;
    assign o_sts.red_last = POW2 || r_cnt;

endmodule

>>> rtl/lsat_ctrl.sv
// ----------------------------------------------------------------------------
// lsat_ctrl
// Sequencer for register commands and memory transfers.
// ----------------------------------------------------------------------------
`include "load_store_address_and_transfer_defines.svh"

module lsat_ctrl
    import lsat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [CMD_W-1:0] i_command,
    input  t_dp_sts          i_sts,
    output t_dp_ctl          o_ctl,
    output logic             busy,
    output logic             o_valid
);

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_command == CMD_EXEC) ? S_ADDR : S_FIN;
                end
            end
            S_ADDR: n_state = S_RED;
            S_RED: begin
                if (i_sts.red_last) begin
                    n_state = S_MEM0;
                end
            end
            S_MEM0: n_state = i_sts.wide ? S_MEM1 : S_FIN;
            S_MEM1: n_state = S_FIN;
            S_FIN:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl   = '0;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: o_ctl.take_in    = start;
            S_ADDR: o_ctl.calc_addr  = 1'b1;
            S_RED:  o_ctl.red_step   = 1'b1;
            S_MEM0: o_ctl.mem_first  = 1'b1;
            S_MEM1: o_ctl.mem_second = 1'b1;
            S_FIN: begin
                o_ctl.finish = 1'b1;
                n_valid      = 1'b1;
            end
            default: o_ctl = '0;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    `LSAT_ASSERT(a_fin_strobe, (r_state == S_FIN) |=> r_valid, "finish without strobe")
    `LSAT_ASSERT(a_strobe_src, r_valid |-> $past(r_state == S_FIN), "strobe without finish")
    `LSAT_ASSERT(a_second_word, (r_state == S_MEM1) |-> $past(r_state == S_MEM0) && i_sts.wide, "second word out of order")
    `LSAT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request accepted but not busy")
    `LSAT_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == S_IDLE) && !r_valid, "reset did not idle")

endmodule

>>> rtl/load_store_address_and_transfer.sv
// ----------------------------------------------------------------------------
// load_store_address_and_transfer
// Load/store unit: 32 x 64-bit register file (entry 31 is the stack pointer)
// and a 32-bit word data memory, with unsigned offset, pre/post-index and
// register offset addressing.
// ----------------------------------------------------------------------------
// channel  | dir | handshake                | payload
// request  | in  | start, busy              | i_command .. i_reg_data
// result   | out | o_valid (one cycle)      | o_result_data, o_word_index
//
// Register write/read: accept, then the finish state registers the strobe.
// Transfer: after accept, busy through the address, word index reduction,
// memory and finish states; a 64-bit transfer adds a second memory state for
// the single memory port. Reduction is a bit slice when MEM_WORDS is a power
// of two, else residue sums per address chunk, then one fold.
// Reset clears the register file at once; data memory is not cleared.
// The result is held until the next request finishes; o_valid flags it as new.
// ----------------------------------------------------------------------------
module load_store_address_and_transfer
    import lsat_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [OFF_W-1:0]  i_offset_field,
    input  logic [REG_AW-1:0] i_base_reg,
    input  logic [REG_AW-1:0] i_target_reg,
    input  logic              i_wide,
    input  logic              i_is_load,
    input  logic              i_unsigned_mode,
    input  logic [DATA_W-1:0] i_reg_data,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_result_data,
    output logic [WIDX_W-1:0] o_word_index
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    lsat_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_sts     (sts),
        .o_ctl     (ctl),
        .busy      (busy),
        .o_valid   (o_valid)
    );

    lsat_dpath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .i_command       (i_command),
        .i_offset_field  (i_offset_field),
        .i_base_reg      (i_base_reg),
        .i_target_reg    (i_target_reg),
        .i_wide          (i_wide),
        .i_is_load       (i_is_load),
        .i_unsigned_mode (i_unsigned_mode),
        .i_reg_data      (i_reg_data),
        .o_result_data   (o_result_data),
        .o_word_index    (o_word_index)
    );

endmodule

>>> tb/sv/lsat_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsat_tb_pkg
// Request and result types plus the scoreboard for the load/store block. The
// scoreboard keeps its own register file and written-word memory, predicts
// each result at request time and checks results in order.
// ----------------------------------------------------------------------------
package lsat_tb_pkg;
    import lsat_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [OFF_W-1:0]  off;
        logic [REG_AW-1:0] base;
        logic [REG_AW-1:0] rt;
        logic              wide;
        logic              is_load;
        logic              umode;
        logic [DATA_W-1:0] data;
    } t_lsat_req;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [WIDX_W-1:0] widx;
    } t_lsat_rsp;

    class ls_scoreboard;
        logic [DATA_W-1:0] regs [REG_N];
        logic [WORD_W-1:0] mem_words [int unsigned];
        t_lsat_rsp         awaited [$];
        int                errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
        endfunction

        function logic [DATA_W-1:0] simm9(logic [OFF_W-1:0] f);
            return {{(DATA_W-SIMM_W){f[10]}}, f[10:2]};
        endfunction

        // address of a transfer, from the register state ahead of it
        function logic [DATA_W-1:0] byte_addr(t_lsat_req r);
            if (r.umode) return regs[r.base] + DATA_W'(r.off);
            if (!r.off[11]) return r.off[1] ? regs[r.base] + simm9(r.off) : regs[r.base];
            return regs[r.off[10:6]] + regs[r.base];
        endfunction

        function int unsigned word_at(logic [DATA_W-1:0] a, int unsigned step);
            logic [DATA_W-1:0] w;
            w = (a >> 2) % DATA_W'(MEM_WORDS_DEF);
            return int'((w + DATA_W'(step)) % DATA_W'(MEM_WORDS_DEF));
        endfunction

        // a load may only touch words already written
        function bit load_safe(t_lsat_req r);
            logic [DATA_W-1:0] a;
            if (r.cmd != CMD_EXEC || !r.is_load) return 1'b1;
            a = byte_addr(r);
            if (!mem_words.exists(word_at(a, 0))) return 1'b0;
            if (r.wide && !mem_words.exists(word_at(a, 1))) return 1'b0;
            return 1'b1;
        endfunction

        function void take_request(t_lsat_req r);
            t_lsat_rsp         e;
            logic [DATA_W-1:0] a;
            int unsigned       w0;
            int unsigned       w1;
            e.data = '0;
            e.widx = '0;
            case (r.cmd)
                CMD_WRITE: begin
                    regs[r.rt] = r.data;
                    e.data = r.data;
                end
                CMD_READ: e.data = regs[r.rt];
                CMD_EXEC: begin
                    a = byte_addr(r);
                    // base writeback lands before the transfer
                    if (!r.umode && !r.off[11])
                        regs[r.base] = r.off[1] ? a : a + simm9(r.off);
                    w0 = word_at(a, 0);
                    w1 = word_at(a, 1);
                    if (!r.wide) begin
                        if (r.is_load) begin
                            e.data = {32'h0, mem_words[w0]};
                            regs[r.rt] = e.data;
                        end else begin
                            e.data = {32'h0, regs[r.rt][31:0]};
                            mem_words[w0] = e.data[31:0];
                        end
                    end else begin
                        if (r.is_load) begin
                            e.data = {mem_words[w0], mem_words[w1]};
                            regs[r.rt] = e.data;
                        end else begin
                            e.data = regs[r.rt];
                            mem_words[w0] = e.data[63:32];
                            mem_words[w1] = e.data[31:0];
                        end
                    end
                    e.widx = WIDX_W'(w0);
                end
                default: ;
            endcase
            awaited.push_back(e);
        endfunction

        function void check_result(logic [DATA_W-1:0] data, logic [WIDX_W-1:0] widx);
            t_lsat_rsp e;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result data %h word_index %h", $time, data, widx);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (data !== e.data) begin
                $display("%0t: result_data expected %h actual %h", $time, e.data, data);
                errors++;
            end
            if (widx !== e.widx) begin
                $display("%0t: word_index expected %h actual %h", $time, e.widx, widx);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Load/store block test: directed transfers in every addressing mode, then
// random register and transfer requests over phases with and without sender
// gaps. Loads are steered onto written words; results checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import lsat_pkg::*;
    import lsat_tb_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 500;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  i_command;
    logic [OFF_W-1:0]  i_offset_field;
    logic [REG_AW-1:0] i_base_reg;
    logic [REG_AW-1:0] i_target_reg;
    logic              i_wide;
    logic              i_is_load;
    logic              i_unsigned_mode;
    logic [DATA_W-1:0] i_reg_data;
    logic              o_valid;
    logic [DATA_W-1:0] o_result_data;
    logic [WIDX_W-1:0] o_word_index;

    ls_scoreboard sb = new();
    int           quiet_cycles;

    load_store_address_and_transfer #(
        .MEM_WORDS(MEM_WORDS_DEF)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_offset_field (i_offset_field),
        .i_base_reg     (i_base_reg),
        .i_target_reg   (i_target_reg),
        .i_wide         (i_wide),
        .i_is_load      (i_is_load),
        .i_unsigned_mode(i_unsigned_mode),
        .i_reg_data     (i_reg_data),
        .o_valid        (o_valid),
        .o_result_data  (o_result_data),
        .o_word_index   (o_word_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_valid) sb.check_result(o_result_data, o_word_index);
            if ((start && !busy) || o_valid) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic t_lsat_req make_req(logic [CMD_W-1:0] cmd, logic [OFF_W-1:0] off,
                                           int base, int rt, bit wide, bit ld, bit umode,
                                           logic [DATA_W-1:0] data);
        t_lsat_req r;
        r.cmd     = cmd;
        r.off     = off;
        r.base    = REG_AW'(base);
        r.rt      = REG_AW'(rt);
        r.wide    = wide;
        r.is_load = ld;
        r.umode   = umode;
        r.data    = data;
        return r;
    endfunction

    // mostly small addresses, some near the top of the space, some anything
    function automatic logic [DATA_W-1:0] rand_reg_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return DATA_W'($urandom_range(0, 4095));
        if (pick < 65) return {32'hFFFF_FFFF, 32'hFFFF_F000 + $urandom_range(0, 4095)};
        return {$urandom, $urandom};
    endfunction

    function automatic int rand_reg_num();
        if ($urandom_range(0, 1)) return $urandom_range(0, 31);
        return $urandom_range(0, 8) == 8 ? 31 : $urandom_range(0, 7);
    endfunction

    function automatic t_lsat_req rand_request();
        t_lsat_req r;
        int        pick;
        int        mode;
        pick = $urandom_range(0, 99);
        r = make_req(CMD_EXEC, OFF_W'($urandom), rand_reg_num(), $urandom_range(0, 31),
                     $urandom_range(0, 1), 1'b0, 1'b0, {$urandom, $urandom});
        if (pick < 15) begin
            r.cmd  = CMD_WRITE;
            r.rt   = REG_AW'(rand_reg_num());
            r.data = rand_reg_value();
            return r;
        end
        if (pick < 23) begin
            r.cmd = CMD_READ;
            return r;
        end
        if (pick < 25) begin
            r.cmd = CMD_NONE;
            return r;
        end
        r.is_load = $urandom_range(0, 99) < 60;
        for (int tries = 0; tries < 8; tries++) begin
            mode    = $urandom_range(0, 9);
            r.base  = REG_AW'(rand_reg_num());
            r.off   = OFF_W'($urandom);
            r.umode = mode < 4;
            if (r.umode && $urandom_range(0, 1)) r.off = OFF_W'($urandom_range(0, 63));
            if (!r.umode) r.off[11] = mode >= 8;
            if (sb.load_safe(r)) break;
        end
        return r;
    endfunction

    task automatic send_request(t_lsat_req r, int gap);
        if (!sb.load_safe(r)) r.is_load = 1'b0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= r.cmd;
        i_offset_field  <= r.off;
        i_base_reg      <= r.base;
        i_target_reg    <= r.rt;
        i_wide          <= r.wide;
        i_is_load       <= r.is_load;
        i_unsigned_mode <= r.umode;
        i_reg_data      <= r.data;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.take_request(r);
        @(negedge i_clk);
    endtask

    initial begin
        t_lsat_req  directed [$];
        int         idle_pct [4];
        int         gap;

        idle_pct = '{0, 70, 0, 23};
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_command       = CMD_EXEC;
        i_offset_field  = '0;
        i_base_reg      = '0;
        i_target_reg    = '0;
        i_wide          = 1'b0;
        i_is_load       = 1'b0;
        i_unsigned_mode = 1'b0;
        i_reg_data      = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed.push_back(make_req(CMD_WRITE, 0, 0, 1, 0, 0, 0, 64'h100));
        directed.push_back(make_req(CMD_WRITE, 0, 0, 2, 0, 0, 0, 64'h40));
        directed.push_back(make_req(CMD_WRITE, 0, 0, 3, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFC));
        directed.push_back(make_req(CMD_WRITE, 0, 0, 4, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        directed.push_back(make_req(CMD_WRITE, 0, 0, 31, 0, 0, 0, 64'h2000));
        directed.push_back(make_req(CMD_WRITE, 0, 0, 8, 0, 0, 0, 64'h800));
        // unsigned offset, both widths, imm12 extremes
        directed.push_back(make_req(CMD_EXEC, 12'h000, 1, 4, 1, 0, 1, 0));
        directed.push_back(make_req(CMD_EXEC, 12'h000, 1, 5, 1, 1, 1, 0));
        directed.push_back(make_req(CMD_EXEC, 12'h004, 1, 6, 0, 1, 1, 0));
        directed.push_back(make_req(CMD_EXEC, 12'hFFF, 1, 4, 0, 0, 1, 0));
        directed.push_back(make_req(CMD_EXEC, 12'hFFF, 1, 7, 0, 1, 1, 0));
        // pre-index -256 on SP, then post-index +255 with bit 0 set
        directed.push_back(make_req(CMD_EXEC, 12'h402, 31, 4, 1, 0, 0, 0));
        directed.push_back(make_req(CMD_EXEC, 12'h3FD, 31, 9, 1, 1, 0, 0));
        // target is base: store of updated base, load over writeback
        directed.push_back(make_req(CMD_EXEC, 12'h022, 8, 8, 1, 0, 0, 0));
        directed.push_back(make_req(CMD_EXEC, 12'h7E0, 8, 8, 1, 1, 0, 0));
        // register offset, low bits set
        directed.push_back(make_req(CMD_EXEC, 12'h8BF, 1, 4, 0, 0, 0, 0));
        directed.push_back(make_req(CMD_EXEC, 12'h8BF, 1, 10, 0, 1, 0, 0));
        // last word, second word wraps to zero
        directed.push_back(make_req(CMD_EXEC, 12'h000, 3, 4, 1, 0, 1, 0));
        directed.push_back(make_req(CMD_EXEC, 12'h000, 3, 11, 1, 1, 1, 0));
        directed.push_back(make_req(CMD_NONE, 12'hFFF, 31, 31, 1, 1, 1, '1));
        directed.push_back(make_req(CMD_READ, 0, 0, 31, 0, 0, 0, 0));
        directed.push_back(make_req(CMD_WRITE, 0, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0001));
        directed.push_back(make_req(CMD_READ, 0, 0, 8, 0, 0, 0, 0));
        foreach (directed[i]) send_request(directed[i], 0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                gap = 0;
                if ($urandom_range(0, 99) < idle_pct[ph]) gap = $urandom_range(1, 7);
                send_request(rand_request(), gap);
            end
        end
        start <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
